// ===== design/fdl_pkg.sv =====
// Shared types and constants for the fractional delay line.
// Used by fdl_store and fractional_delay_line; depends on nothing else.
package fdl_pkg;

    // Sample and delay register formats.
    localparam int SAMPLE_W = 24;
    localparam int DELAY_W  = 20;
    localparam int FRAC_W   = 8;
    localparam int WGT_W    = FRAC_W + 1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_DELAY_Q8    = 1'b0,
        REG_INTERPOLATE = 1'b1
    } cfg_reg_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ===== design/fdl_store.sv =====
// Sample store of the fractional delay line: two copies of one circular buffer.
// Both copies take the same write; each serves one registered read port.
// Depends on fdl_pkg.
module fdl_store
    import fdl_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  sample_t       wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_i,
    input  logic [AW-1:0] rd_addr_n,
    output sample_t       rd_data_i,
    output sample_t       rd_data_n
);

    sample_t mem_i [DEPTH];
    sample_t mem_n [DEPTH];

    // Copy that serves the tap at the integer read position.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_i[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_i <= mem_i[rd_addr_i];
        end
    end

    // Copy that serves the tap one slot further on.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_n[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_n <= mem_n[rd_addr_n];
        end
    end

endmodule

// ===== design/fractional_delay_line.sv =====
// Fractional delay line: circular sample buffer with linear interpolation.
// Depends on fdl_pkg and fdl_store.
//
// One sample beat is taken every clock cycle while the output is not stalled,
// and each gives one output beat through the memory read, weighting multiply,
// and sum and output register stages. The buffer is held twice, so the write
// of the new sample and the reads of both interpolation taps happen in the
// same cycle; a read of the slot being written in the same cycle is forwarded
// from the input. Slots not yet written since reset read as zero through a
// fill flag, so there is no clearing pass after reset. Delay writes are
// clamped to DEPTH-1 samples when written and apply to the next sample beat.
module fractional_delay_line
    import fdl_pkg::*;
#(
    parameter int DEPTH = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [23:0]  sample_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [23:0]  sample_out,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [19:0]         cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int DW = AW + FRAC_W;
    localparam int CW = (DW > DELAY_W) ? DW : DELAY_W;
    localparam logic [CW-1:0] DMAX = CW'((DEPTH - 1) * (1 << FRAC_W));
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam int PW = SAMPLE_W + WGT_W + 1;

    // Configuration state, kept in decoded form.
    logic [AW-1:0]     dint_reg, dint_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [AW:0]       back_reg, back_next;
    logic              interp_reg, interp_next;

    // Write pointer and fill flag.
    logic [AW-1:0] wpos_reg, wpos_next;
    logic          full_reg, full_next;

    // Pipeline occupancy.
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic out_valid_reg, out_valid_next;
    logic en1, en2, en_out, accept;

    // Stage 1 payload.
    logic                hit_i_reg, hit_n_reg, keep_i_reg, keep_n_reg;
    sample_t             fwd_reg;
    logic [WGT_W-1:0]    wgt_i_reg;
    logic [FRAC_W-1:0]   wgt_n_reg;

    // Stage 2 payload and output register.
    logic signed [PW-1:0] prod_i_reg, prod_n_reg, prod_i_next, prod_n_next;
    sample_t              out_reg, out_next;

    // Stage 0 address and weight logic.
    logic [CW-1:0]      dly_ext, dly_cl;
    logic [AW:0]        diff_i, diff_n;
    logic [AW-1:0]      addr_i, addr_n;
    logic               keep_i, keep_n, hit_i, hit_n;
    logic [WGT_W-1:0]   wgt_i;
    logic [FRAC_W-1:0]  wgt_n;
    sample_t            rd_i, rd_n, tap_i, tap_n;
    logic signed [PW:0] sum;

    // Handshake: each stage loads when it is empty or its successor moves.
    assign en_out    = !out_valid_reg || !out_stall;
    assign en2       = !v2_reg || en_out;
    assign en1       = !v1_reg || en2;
    assign in_stall  = !en1;
    assign accept    = in_valid && en1;
    assign out_valid = out_valid_reg;
    assign sample_out = out_reg;

    // Config writes: clamp the delay, split into integer and fraction; set interp flag.
    always_comb
    begin
        dint_next   = dint_reg;
        frac_next   = frac_reg;
        back_next   = back_reg;
        interp_next = interp_reg;
        dly_ext     = CW'(cfg_data);
        dly_cl      = (dly_ext > DMAX) ? DMAX : dly_ext;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DELAY_Q8:
                begin
                    dint_next = dly_cl[DW-1:FRAC_W];
                    frac_next = dly_cl[FRAC_W-1:0];
                    back_next = {1'b0, dly_cl[DW-1:FRAC_W]}
                              + (AW+1)'(dly_cl[FRAC_W-1:0] != '0);
                end
                REG_INTERPOLATE:
                begin
                    interp_next = cfg_data[0];
                end
                default:
                begin
                    interp_next = interp_reg;
                end
            endcase
        end
    end

    // Read positions: floor of the fractional position and the slot after it.
    always_comb
    begin
        diff_i = {1'b0, wpos_reg} - back_reg;
        diff_n = {1'b0, wpos_reg} - {1'b0, dint_reg};
        addr_i = diff_i[AW] ? diff_i[AW-1:0] + LAST + AW'(1) : diff_i[AW-1:0];
        addr_n = diff_n[AW] ? diff_n[AW-1:0] + LAST + AW'(1) : diff_n[AW-1:0];
        hit_i  = (addr_i == wpos_reg);
        hit_n  = (addr_n == wpos_reg);
        keep_i = full_reg || (addr_i <= wpos_reg);
        keep_n = full_reg || (addr_n <= wpos_reg);
    end

    // Tap weights; raw mode puts the full weight on the integer tap.
    always_comb
    begin
        if (!interp_reg || (frac_reg == '0))
        begin
            wgt_i = WGT_W'(1 << FRAC_W);
            wgt_n = '0;
        end
        else
        begin
            wgt_i = {1'b0, frac_reg};
            wgt_n = FRAC_W'(WGT_W'(1 << FRAC_W) - {1'b0, frac_reg});
        end
    end

    // Write pointer and fill flag advance on each accepted beat.
    always_comb
    begin
        wpos_next = wpos_reg;
        full_next = full_reg;
        if (accept)
        begin
            if (wpos_reg == LAST)
            begin
                wpos_next = '0;
                full_next = 1'b1;
            end
            else
            begin
                wpos_next = wpos_reg + AW'(1);
            end
        end
    end

    // Occupancy of the pipeline stages.
    always_comb
    begin
        v1_next        = en1 ? in_valid : v1_reg;
        v2_next        = en2 ? v1_reg : v2_reg;
        out_valid_next = en_out ? v2_reg : out_valid_reg;
    end

    // Stage 1: pick forwarded, stored or zero taps and weight them.
    always_comb
    begin
        tap_i = hit_i_reg ? fwd_reg : (keep_i_reg ? rd_i : '0);
        tap_n = hit_n_reg ? fwd_reg : (keep_n_reg ? rd_n : '0);
        prod_i_next = PW'(tap_i * $signed({1'b0, wgt_i_reg}));
        prod_n_next = PW'(tap_n * $signed({2'b00, wgt_n_reg}));
    end

    // Stage 2: sum of products, floored by dropping the fraction bits.
    always_comb
    begin
        sum      = (PW+1)'(prod_i_reg) + (PW+1)'(prod_n_reg);
        out_next = sum[SAMPLE_W+FRAC_W-1:FRAC_W];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dint_reg      <= AW'(1);
            frac_reg      <= '0;
            back_reg      <= (AW+1)'(1);
            interp_reg    <= 1'b1;
            wpos_reg      <= '0;
            full_reg      <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dint_reg      <= dint_next;
            frac_reg      <= frac_next;
            back_reg      <= back_next;
            interp_reg    <= interp_next;
            wpos_reg      <= wpos_next;
            full_reg      <= full_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            hit_i_reg  <= hit_i;
            hit_n_reg  <= hit_n;
            keep_i_reg <= keep_i;
            keep_n_reg <= keep_n;
            fwd_reg    <= sample_in;
            wgt_i_reg  <= wgt_i;
            wgt_n_reg  <= wgt_n;
        end
        if (en2)
        begin
            prod_i_reg <= prod_i_next;
            prod_n_reg <= prod_n_next;
        end
        if (en_out)
        begin
            out_reg <= out_next;
        end
    end

    // Sample buffer.
    fdl_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .wr_en     (accept),
        .wr_addr   (wpos_reg),
        .wr_data   (sample_in),
        .rd_en     (en1),
        .rd_addr_i (addr_i),
        .rd_addr_n (addr_n),
        .rd_data_i (rd_i),
        .rd_data_n (rd_n)
    );

`ifndef NO_ASSERTIONS
    // The write pointer steps by one for each accepted beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (wpos_reg != LAST)) |=> (wpos_reg == $past(wpos_reg) + AW'(1)))
        else $error("write pointer did not advance on an accepted beat");

    // Once the buffer has wrapped, every slot stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("fill flag dropped after the buffer wrapped");

    // The input is held off only when every stage is occupied and the output waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline had room");

    // A beat in stage 2 is not lost while the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && out_valid_reg && out_stall) |=> v2_reg)
        else $error("stage 2 beat dropped under output stall");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for fractional_delay_line: random and corner sample beats
// with idle and stall gaps on both sides, checked against an in-bench delay line model.
// Depends on fdl_pkg and the fractional_delay_line RTL.
module testbench
    import fdl_pkg::*;
();

    localparam int DEPTH          = 4096;
    localparam int LATENCY        = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BEATS    = 100;
    localparam int RANDOM_PHASES  = 10;
    localparam logic [19:0] MAX_DELAY  = 20'((DEPTH - 1) * 256);
    localparam sample_t     SAMPLE_MAX = 24'sh7FFFFF;
    localparam sample_t     SAMPLE_MIN = 24'sh800000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    sample_t     sample_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    sample_t     sample_out;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [19:0] cfg_data  = '0;

    // Samples waiting to be sent, and delayed samples waiting to come out.
    sample_t pending_samples[$];
    sample_t expected_samples[$];

    // Model of the delay line: store, write pointer and register copies.
    sample_t     model_store [DEPTH];
    logic [11:0] model_wpos;
    logic [19:0] model_delay;
    logic        model_interp;

    logic in_taken    = 1'b0;
    bit   calm        = 1'b0;
    int   fail_count  = 0;
    int   quiet_cycles = 0;

    fractional_delay_line #(.DEPTH(DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Writes one sample into the model and returns the delayed sample it reads.
    function automatic sample_t delayed_sample_of(sample_t s);
        logic [19:0] d;
        logic [19:0] p;
        logic [11:0] idx;
        logic [11:0] nxt;
        longint      acc;
        sample_t     result;
        model_store[model_wpos] = s;
        d = (model_delay > MAX_DELAY) ? MAX_DELAY : model_delay;
        // The store spans exactly 2^20 in Q8 units, so the wrap is free.
        p = {model_wpos, 8'h00} - d;
        idx = p[19:8];
        nxt = idx + 12'd1;
        if (model_interp)
        begin
            acc = longint'(model_store[idx]) * (256 - longint'(p[7:0]))
                + longint'(model_store[nxt]) * longint'(p[7:0]);
            // Bits above the drop are a floor division by 256.
            result = acc[31:8];
        end
        else
        begin
            result = model_store[idx];
        end
        model_wpos = model_wpos + 12'd1;
        return result;
    endfunction

    function automatic bit idle_draw();
        return !calm && ($urandom_range(99) < 32);
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'($signed($urandom_range(32)) - 16);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Mostly short delays so that reads land on recent samples; extremes now and then.
    function automatic logic [19:0] random_delay();
        case ($urandom_range(7))
            0:       return 20'd0;
            1:       return MAX_DELAY;
            2:       return 20'($urandom_range(20'hFFFFF, int'(MAX_DELAY) + 1));
            3:       return 20'($urandom);
            default: return 20'($urandom_range(64 * 256));
        endcase
    endfunction

    // Sender: a new beat goes out once the previous one was taken.
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (pending_samples.size() != 0 && !idle_draw())
            begin
                in_valid  <= 1'b1;
                sample_in <= pending_samples.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= idle_draw();
    end

    // Prediction on each accepted input beat, checking of each output beat, and watchdog.
    always @(posedge clk)
    begin
        sample_t want;
        logic    out_taken;
        in_taken  = in_valid && !in_stall;
        out_taken = out_valid && !out_stall;
        if (in_taken)
            expected_samples.push_back(delayed_sample_of(sample_in));
        if (out_taken)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample_out beat with no expected sample: actual %0d", sample_out);
                fail_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (sample_out !== want)
                begin
                    $error("sample_out mismatch: expected %0d, actual %0d", want, sample_out);
                    fail_count++;
                end
            end
        end
        if (in_taken || out_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Wait until every queued beat has gone in and every expected beat has come out.
    task automatic settle();
        while (pending_samples.size() != 0 || in_valid || expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [19:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_DELAY_Q8)
            model_delay = value;
        else
            model_interp = value[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Registers change only with the line drained.
    task automatic program_line(logic [19:0] delay, logic [19:0] interp_word);
        settle();
        repeat (LATENCY + 2) @(negedge clk);
        write_reg(REG_DELAY_Q8, delay);
        write_reg(REG_INTERPOLATE, interp_word);
    endtask

    initial
    begin
        int      k;
        int      n;
        sample_t corners [6];
        for (k = 0; k < DEPTH; k++)
            model_store[k] = '0;
        model_wpos   = '0;
        model_delay  = 20'd256;
        model_interp = 1'b1;
        corners = '{SAMPLE_MAX, SAMPLE_MIN, 24'sd0, -24'sd1, 24'sd1, 24'sh555555};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: one sample of delay, interpolating, over a zeroed store.
        for (k = 0; k < 6; k++)
            pending_samples.push_back(corners[k]);

        // Zero delay returns the sample just written.
        program_line(20'd0, 20'd1);
        pending_samples.push_back(SAMPLE_MIN);
        pending_samples.push_back(SAMPLE_MAX);
        pending_samples.push_back(24'sh2AAAAA);

        // Half-sample delay: odd sums of negative samples must floor.
        program_line(20'd128, 20'd1);
        pending_samples.push_back(-24'sd1);
        pending_samples.push_back(24'sd1);
        pending_samples.push_back(SAMPLE_MIN);
        pending_samples.push_back(SAMPLE_MAX);
        pending_samples.push_back(-24'sd3);

        // Delay beyond the store is clamped; raw read with upper bits set in the word.
        program_line(20'hFFFFF, 20'hFFFFE);
        pending_samples.push_back(SAMPLE_MAX);
        pending_samples.push_back(SAMPLE_MIN);
        pending_samples.push_back(24'sh123456);

        // Longest legal delay, then just under it with the largest fraction.
        program_line(MAX_DELAY, 20'h00001);
        pending_samples.push_back(-24'sd7);
        pending_samples.push_back(24'sh3FFFFF);
        program_line(MAX_DELAY - 20'd1, 20'h00001);
        pending_samples.push_back(SAMPLE_MIN);
        pending_samples.push_back(SAMPLE_MAX);

        // Random phases, each with fresh register values; one phase runs without gaps.
        for (n = 0; n < RANDOM_PHASES; n++)
        begin
            program_line(random_delay(), 20'($urandom));
            calm = (n == 3);
            for (k = 0; k < PHASE_BEATS; k++)
                pending_samples.push_back(random_sample());
        end

        settle();
        repeat (LATENCY + 5) @(posedge clk);
        if (fail_count == 0 && expected_samples.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
